// ----- rtl/mfrh_pkg.sv -----
// ----------------------------------------------------------------------------
// mfrh_pkg: shared types and constants
// Geometry limits, register indexes and the job record that travels from the
// front end through the job queue to the median engine.
// ----------------------------------------------------------------------------
package mfrh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int NUM_BINS   = 256;
    localparam int ROW_SLOTS  = 2 * MAX_RADIUS + 1;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SLOT_W  = $clog2(ROW_SLOTS);
    localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 1);
    localparam int RAD_W   = 3;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;
    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int CNT_W   = 8;
    localparam int PIX_W   = 24;
    localparam int LS_DEPTH = ROW_SLOTS * MAX_WIDTH;
    localparam int LS_AW   = $clog2(LS_DEPTH);

    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic              valid;
        logic [ROW_W-1:0]  center_row;
        logic [COL_W-1:0]  center_col;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] top_slot;
        logic [COL_W-1:0]  col;
        logic [SPAN_W-1:0] span;
    } job_t;

endpackage

// ----- rtl/median_filter_running_hist.sv -----
// ----------------------------------------------------------------------------
// median_filter_running_hist: streaming RGB 2-D median filter
// Per-channel median of every (2R+1) square window that fits in the frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pix channel (pix_valid, pix_stall);
// one result item per pixel leaves on the med channel (med_valid,
// med_stall). A result carries the three medians, out_valid, the window
// centre and frame_last; when out_valid is low the medians and centre are
// zero. Geometry is written through cfg_we, cfg_index and cfg_data; the
// user is to write it only while the block is idle, which the block does
// not enforce. A pixel that completes no window goes from the store state
// straight to the done state. For a pixel that completes a window with
// span n = 2R+1, the engine reads one line-store entry and updates the
// histograms in the LREAD, HREAD and HWRITE states per window pixel, then
// walks all 256 bins, clearing them as it goes. A two-item job queue lets
// pixels enter while the engine works. After reset the histograms are
// cleared, with pix_stall high. A stalled result holds in the output
// register; the engine then waits and the queue fills, then pix_stall rises.
// ----------------------------------------------------------------------------
module median_filter_running_hist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mfrh_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mfrh_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [7:0]                    pix_red,
    input  logic [7:0]                    pix_green,
    input  logic [7:0]                    pix_blue,
    output logic                          med_valid,
    input  logic                          med_stall,
    output logic [7:0]                    med_red,
    output logic [7:0]                    med_green,
    output logic [7:0]                    med_blue,
    output logic                          out_valid,
    output logic [mfrh_pkg::ROW_W-1:0]    center_row,
    output logic [mfrh_pkg::COL_W-1:0]    center_col,
    output logic                          frame_last
);
    import mfrh_pkg::*;

    job_t new_job;
    job_t head;
    logic accept;
    logic pop;
    logic full;
    logic empty;
    logic clearing;

    assign pix_stall = full || clearing;
    assign accept    = pix_valid && !pix_stall;

    mfrh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pix_red   (pix_red),
        .pix_green (pix_green),
        .pix_blue  (pix_blue),
        .job       (new_job)
    );

    mfrh_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (new_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    mfrh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (empty),
        .pop        (pop),
        .clearing   (clearing),
        .med_valid  (med_valid),
        .med_stall  (med_stall),
        .med_red    (med_red),
        .med_green  (med_green),
        .med_blue   (med_blue),
        .out_valid  (out_valid),
        .center_row (center_row),
        .center_col (center_col),
        .frame_last (frame_last)
    );

`ifndef SYNTHESIS
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (med_valid && !out_valid) |-> (med_red == 8'd0 && med_green == 8'd0 &&
        med_blue == 8'd0 && center_row == '0 && center_col == '0))
        else $error("invalid result carries nonzero payload");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("job queue both full and empty");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !med_valid)
        else $error("result shown during histogram clear");
`endif

endmodule

// ----- rtl/mfrh_front.sv -----
// ----------------------------------------------------------------------------
// mfrh_front: configuration and raster classification
// Holds the geometry registers and the raster counters, and turns each
// incoming pixel into a job record for the median engine.
// ----------------------------------------------------------------------------
module mfrh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mfrh_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mfrh_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          accept,
    input  logic [7:0]                    pix_red,
    input  logic [7:0]                    pix_green,
    input  logic [7:0]                    pix_blue,
    output mfrh_pkg::job_t                job
);
    import mfrh_pkg::*;

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [RAD_W-1:0]  window_radius_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [SPAN_W-1:0] span;
    logic              row_end;
    logic              last;
    logic              valid;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = FW_W'(1);
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg == '0)
            h_eff = FH_W'(1);
        else if (frame_height_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
        span    = SPAN_W'({window_radius_reg, 1'b0});
        row_end = (FW_W'(col_reg) + FW_W'(1)) >= w_eff;
        last    = row_end && ((FH_W'(row_reg) + FH_W'(1)) >= h_eff);
        valid   = (row_reg >= ROW_W'(span)) && (col_reg >= COL_W'(span));

        job.pix        = {pix_red, pix_green, pix_blue};
        job.valid      = valid;
        job.center_row = valid ? row_reg - ROW_W'(window_radius_reg) : '0;
        job.center_col = valid ? col_reg - COL_W'(window_radius_reg) : '0;
        job.last       = last;
        job.slot       = slot_reg;
        job.col        = col_reg;
        job.span       = span;
        if (slot_reg >= SLOT_W'(span))
            job.top_slot = slot_reg - SLOT_W'(span);
        else
            job.top_slot = slot_reg + SLOT_W'(ROW_SLOTS) - SLOT_W'(span);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FW_W'(640);
            frame_height_reg  <= FH_W'(480);
            window_radius_reg <= RAD_W'(1);
            row_reg           <= '0;
            col_reg           <= '0;
            slot_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[FH_W-1:0];
                    REG_WINDOW_RADIUS: window_radius_reg <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    if (last)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + ROW_W'(1);
                        slot_reg <= (slot_reg == SLOT_W'(ROW_SLOTS - 1)) ? '0
                                    : slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/mfrh_fifo.sv -----
// ----------------------------------------------------------------------------
// mfrh_fifo: two-entry job queue
// Decouples the front end from the median engine.
// ----------------------------------------------------------------------------
module mfrh_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mfrh_pkg::job_t push_job,
    input  logic           pop,
    output mfrh_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import mfrh_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/mfrh_back.sv -----
// ----------------------------------------------------------------------------
// mfrh_back: median engine
// Writes each pixel into the line store, builds the three channel histograms
// of the window one pixel at a time, walks the bins for the rank and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module mfrh_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfrh_pkg::job_t               head,
    input  logic                         fifo_empty,
    output logic                         pop,
    output logic                         clearing,
    output logic                         med_valid,
    input  logic                         med_stall,
    output logic [7:0]                   med_red,
    output logic [7:0]                   med_green,
    output logic [7:0]                   med_blue,
    output logic                         out_valid,
    output logic [mfrh_pkg::ROW_W-1:0]   center_row,
    output logic [mfrh_pkg::COL_W-1:0]   center_col,
    output logic                         frame_last
);
    import mfrh_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_STORE  = 8'b0000_0100,
        ST_LREAD  = 8'b0000_1000,
        ST_HREAD  = 8'b0001_0000,
        ST_HWRITE = 8'b0010_0000,
        ST_WALK   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    job_t              job_reg;
    logic [SPAN_W-1:0] i_reg;
    logic [SPAN_W-1:0] j_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [COL_W-1:0]  col_base_reg;
    logic [CNT_W-1:0]  rank_reg;
    logic [BIN_W:0]    cnt_reg;
    logic [PIX_W-1:0]  vpix_reg;
    logic [7:0]        med_reg   [3];
    logic [CNT_W-1:0]  cum_reg   [3];
    logic [2:0]        found_reg;
    logic              out_load;

    logic [PIX_W-1:0]  ls_mem [LS_DEPTH];
    logic [PIX_W-1:0]  ls_rd;
    logic              ls_we;
    logic [LS_AW-1:0]  ls_wa;
    logic [LS_AW-1:0]  ls_ra;

    logic              h_we;
    logic [2:0][7:0]   h_ra;
    logic [2:0][7:0]   h_wa;
    logic [2:0][7:0]   h_wd;
    logic [2:0][7:0]   h_rd;

    logic [SPAN_W-1:0] n_val;
    logic [CNT_W-1:0]  nn_val;
    logic [CNT_W:0]    rank_sum;

    assign clearing = (state_reg == ST_CLEAR);
    assign pop      = (state_reg == ST_IDLE) && !fifo_empty;
    assign out_load = (state_reg == ST_DONE) && (!med_valid || !med_stall);

    assign n_val    = head.span + SPAN_W'(1);
    assign nn_val   = CNT_W'(n_val) * CNT_W'(n_val);
    assign rank_sum = {1'b0, nn_val} + (CNT_W + 1)'(1);

    assign ls_we = (state_reg == ST_STORE);
    assign ls_wa = LS_AW'(job_reg.slot) * LS_AW'(MAX_WIDTH) + LS_AW'(job_reg.col);
    assign ls_ra = LS_AW'(rslot_reg) * LS_AW'(MAX_WIDTH)
                 + LS_AW'(col_base_reg + COL_W'(j_reg));

    always_ff @(posedge clk)
    begin
        if (ls_we)
            ls_mem[ls_wa] <= job_reg.pix;
        ls_rd <= ls_mem[ls_ra];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_hist
        logic [CNT_W-1:0] hist_mem [NUM_BINS];

        always_ff @(posedge clk)
        begin
            if (h_we)
                hist_mem[h_wa[k]] <= h_wd[k];
            h_rd[k] <= hist_mem[h_ra[k]];
        end
    end

    always_comb
    begin
        h_we = 1'b0;
        h_ra = '0;
        h_wa = '0;
        h_wd = '0;
        for (int k = 0; k < 3; k++)
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    h_we    = 1'b1;
                    h_wa[k] = cnt_reg[BIN_W-1:0];
                end
                ST_HREAD:
                begin
                    h_ra[k] = ls_rd[(2 - k) * 8 +: 8];
                end
                ST_HWRITE:
                begin
                    h_we    = 1'b1;
                    h_wa[k] = vpix_reg[(2 - k) * 8 +: 8];
                    h_wd[k] = h_rd[k] + 8'd1;
                end
                ST_WALK:
                begin
                    h_we    = !cnt_reg[BIN_W];
                    h_ra[k] = cnt_reg[BIN_W-1:0];
                    h_wa[k] = cnt_reg[BIN_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (cnt_reg == (BIN_W + 1)'(NUM_BINS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (!fifo_empty)
                    state_next = ST_STORE;
            ST_STORE:
                state_next = job_reg.valid ? ST_LREAD : ST_DONE;
            ST_LREAD:
                state_next = ST_HREAD;
            ST_HREAD:
                state_next = ST_HWRITE;
            ST_HWRITE:
                if (j_reg == job_reg.span && i_reg == job_reg.span)
                    state_next = ST_WALK;
                else
                    state_next = ST_LREAD;
            ST_WALK:
                if (cnt_reg[BIN_W])
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            med_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR || (state_reg == ST_WALK && !cnt_reg[BIN_W]))
                cnt_reg <= cnt_reg + (BIN_W + 1)'(1);
            else if (state_reg == ST_HWRITE)
                cnt_reg <= '0;
            if (out_load)
                med_valid <= 1'b1;
            else if (!med_stall)
                med_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= head;
                rank_reg <= rank_sum[CNT_W:1];
            end
            ST_STORE:
            begin
                i_reg        <= '0;
                j_reg        <= '0;
                rslot_reg    <= job_reg.top_slot;
                col_base_reg <= job_reg.col - COL_W'(job_reg.span);
                found_reg    <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    med_reg[k] <= '0;
                    cum_reg[k] <= '0;
                end
            end
            ST_HREAD:
                vpix_reg <= ls_rd;
            ST_HWRITE:
            begin
                if (j_reg == job_reg.span)
                begin
                    j_reg     <= '0;
                    i_reg     <= i_reg + SPAN_W'(1);
                    rslot_reg <= (rslot_reg == SLOT_W'(ROW_SLOTS - 1)) ? '0
                                 : rslot_reg + SLOT_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + SPAN_W'(1);
                end
            end
            ST_WALK:
            begin
                if (cnt_reg != '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!found_reg[k] &&
                            ({1'b0, cum_reg[k]} + {1'b0, h_rd[k]}) >= {1'b0, rank_reg})
                        begin
                            med_reg[k]   <= 8'(cnt_reg - (BIN_W + 1)'(1));
                            found_reg[k] <= 1'b1;
                        end
                        cum_reg[k] <= cum_reg[k] + h_rd[k];
                    end
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            med_red    <= med_reg[0];
            med_green  <= med_reg[1];
            med_blue   <= med_reg[2];
            out_valid  <= job_reg.valid;
            center_row <= job_reg.center_row;
            center_col <= job_reg.center_col;
            frame_last <= job_reg.last;
        end
    end

endmodule
